[rtl/core/mtb_pkg.sv]
// Types, constants and the control store for the timer bank.
package mtb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int COUNT_W    = 32;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int ID_W       = 4;
    localparam int MAX_RES    = 16;
    localparam int NREP_W     = $clog2(MAX_RES + 1);
    localparam int PC_W       = 3;

    typedef enum logic [2:0] {
        ACT_INIT    = 3'd0,
        ACT_START   = 3'd1,
        ACT_STOP    = 3'd2,
        ACT_DESTROY = 3'd3,
        ACT_TICK    = 3'd4,
        ACT_QUERY   = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        PH_UNUSED    = 3'd0,
        PH_CREATED   = 3'd1,
        PH_STARTED   = 3'd2,
        PH_STOPPED   = 3'd3,
        PH_DESTROYED = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        UOP_FETCH = 2'd0,
        UOP_SCAN  = 2'd1,
        UOP_FLUSH = 2'd2,
        UOP_APPLY = 2'd3
    } t_uop;

    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_FETCH = 3'd0;
    localparam t_pc PC_HARD  = 3'd1;
    localparam t_pc PC_SOFT  = 3'd2;
    localparam t_pc PC_FLUSH = 3'd3;
    localparam t_pc PC_APPLY = 3'd4;

    typedef struct packed {
        t_uop uop;
        logic want_hard;
        t_pc  next_pc;
    } t_uword;

    typedef struct packed {
        logic go_tick;
        logic go_apply;
        logic advance;
    } t_seq_stat;

    typedef struct packed {
        logic [ID_W-1:0]    timer;
        logic               fired;
        logic               status;
        t_phase             life;
        logic [COUNT_W-1:0] dly;
        logic [COUNT_W-1:0] per;
        logic               kind;
        logic [COUNT_W-1:0] rem;
        logic               last;
    } t_result;

    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        case (pc)
            PC_FETCH: w = '{uop: UOP_FETCH, want_hard: 1'b0, next_pc: PC_FETCH};
            PC_HARD:  w = '{uop: UOP_SCAN,  want_hard: 1'b1, next_pc: PC_SOFT};
            PC_SOFT:  w = '{uop: UOP_SCAN,  want_hard: 1'b0, next_pc: PC_FLUSH};
            PC_FLUSH: w = '{uop: UOP_FLUSH, want_hard: 1'b0, next_pc: PC_FETCH};
            PC_APPLY: w = '{uop: UOP_APPLY, want_hard: 1'b0, next_pc: PC_FETCH};
            default:  w = '{uop: UOP_FETCH, want_hard: 1'b0, next_pc: PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/mtb_seq.sv]
// Microcode sequencer: step counter over the control store.
module mtb_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtb_pkg::t_seq_stat i_stat,
    output mtb_pkg::t_uword    o_uword
);

    mtb_pkg::t_pc r_pc;
    mtb_pkg::t_pc n_pc;

    assign o_uword = mtb_pkg::ucode_rom(r_pc);

    always_comb begin
        n_pc = r_pc;
        if (o_uword.uop == mtb_pkg::UOP_FETCH) begin
            if (i_stat.go_tick) begin
                n_pc = mtb_pkg::PC_HARD;
            end else if (i_stat.go_apply) begin
                n_pc = mtb_pkg::PC_APPLY;
            end
        end else if (i_stat.advance) begin
            n_pc = o_uword.next_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= mtb_pkg::PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[rtl/core/multi_timer_bank_unit.sv]
// Top level of the timer bank: timer registers, result staging, sequencer.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------------------------
//  request | i_in_valid  | o_in_stall  | i_action i_timer_id i_start_delay i_period
//          |             |             | i_hard_kind
//  result  | o_out_valid | i_out_stall | o_result_timer o_fired o_status o_life_state
//          |             |             | o_delay_out o_period_out o_kind_out
//          |             |             | o_remaining o_last
//
// One request at a time. Non-tick requests pass through fetch, then apply; reserved actions are dropped at fetch.
// Tick: fetch, then two sweeps of the timer registers (hard sweep then soft sweep),
// one timer per cycle while no report is held back by the output, then flush.
// Results of a tick are staged one behind, so the last one can carry o_last.
// Output stall only adds cycles when a sweep, flush or apply step finds the output full.
// Synchronous active-low reset clears all timers to unused and zero.
module multi_timer_bank_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_action,
    input  logic [mtb_pkg::ID_W-1:0]    i_timer_id,
    input  logic [mtb_pkg::COUNT_W-1:0] i_start_delay,
    input  logic [mtb_pkg::COUNT_W-1:0] i_period,
    input  logic                        i_hard_kind,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mtb_pkg::ID_W-1:0]    o_result_timer,
    output logic                        o_fired,
    output logic                        o_status,
    output logic [2:0]                  o_life_state,
    output logic [mtb_pkg::COUNT_W-1:0] o_delay_out,
    output logic [mtb_pkg::COUNT_W-1:0] o_period_out,
    output logic                        o_kind_out,
    output logic [mtb_pkg::COUNT_W-1:0] o_remaining,
    output logic                        o_last
);

    localparam int NT = mtb_pkg::NUM_TIMERS;
    localparam int CW = mtb_pkg::COUNT_W;
    localparam int IW = mtb_pkg::IDX_W;

    mtb_pkg::t_uword    uw;
    mtb_pkg::t_seq_stat st;

    logic [CW-1:0]       r_dly [NT];
    logic [CW-1:0]       r_per [NT];
    logic [CW-1:0]       r_cnt [NT];
    logic                r_kind [NT];
    mtb_pkg::t_phase     r_ph [NT];

    logic [2:0]                 r_act, n_act;
    logic [mtb_pkg::ID_W-1:0]   r_id, n_id;
    logic [CW-1:0]              r_in_dly, n_in_dly;
    logic [CW-1:0]              r_in_per, n_in_per;
    logic                       r_in_hard, n_in_hard;
    logic [IW-1:0]              r_idx, n_idx;
    logic [mtb_pkg::NREP_W-1:0] r_nrep, n_nrep;
    logic                       r_pend_valid, n_pend_valid;
    mtb_pkg::t_result           r_pend, n_pend;
    logic                       r_out_valid, n_out_valid;
    mtb_pkg::t_result           r_out, n_out;

    logic            in_acc, out_free;
    logic [IW-1:0]   rd_idx;
    logic [CW-1:0]   cur_dly, cur_per, cur_cnt, cur_dec;
    logic            cur_kind;
    mtb_pkg::t_phase cur_ph;
    logic            sel, fire, report, blocked, bad_id;

    logic            wr_en;
    logic [CW-1:0]   wr_dly, wr_per, wr_cnt;
    logic            wr_kind;
    mtb_pkg::t_phase wr_ph;
    logic            wr_status;
    mtb_pkg::t_result res;

    mtb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (st),
        .o_uword (uw)
    );

    assign o_in_stall = (uw.uop != mtb_pkg::UOP_FETCH);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign rd_idx   = (uw.uop == mtb_pkg::UOP_SCAN) ? r_idx : IW'(r_id);
    assign cur_dly  = r_dly[rd_idx];
    assign cur_per  = r_per[rd_idx];
    assign cur_cnt  = r_cnt[rd_idx];
    assign cur_kind = r_kind[rd_idx];
    assign cur_ph   = r_ph[rd_idx];
    assign cur_dec  = cur_cnt - CW'(1);
    assign bad_id   = int'(r_id) >= NT;

    // tick sweep step
    assign sel     = (cur_ph == mtb_pkg::PH_STARTED) && (cur_kind == uw.want_hard);
    assign fire    = sel && ((cur_cnt == '0) || (cur_dec == '0));
    assign report  = fire && (int'(r_nrep) < mtb_pkg::MAX_RES);
    assign blocked = report && r_pend_valid && !out_free;

    always_comb begin
        n_act        = r_act;
        n_id         = r_id;
        n_in_dly     = r_in_dly;
        n_in_per     = r_in_per;
        n_in_hard    = r_in_hard;
        n_idx        = r_idx;
        n_nrep       = r_nrep;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        st           = '0;
        wr_en        = 1'b0;
        wr_dly       = cur_dly;
        wr_per       = cur_per;
        wr_cnt       = cur_cnt;
        wr_kind      = cur_kind;
        wr_ph        = cur_ph;
        wr_status    = 1'b0;

        case (uw.uop)
            mtb_pkg::UOP_SCAN: begin
                if (sel) begin
                    if (fire) begin
                        if (cur_per != '0) begin
                            wr_cnt = cur_per;
                        end else begin
                            wr_cnt = '0;
                            wr_ph  = mtb_pkg::PH_STOPPED;
                        end
                    end else begin
                        wr_cnt = cur_dec;
                    end
                end
            end
            mtb_pkg::UOP_APPLY: begin
                case (r_act)
                    mtb_pkg::ACT_INIT: begin
                        wr_dly  = r_in_dly;
                        wr_per  = r_in_per;
                        wr_kind = r_in_hard;
                        wr_cnt  = (r_in_dly != '0) ? r_in_dly : r_in_per;
                        wr_ph   = mtb_pkg::PH_CREATED;
                    end
                    mtb_pkg::ACT_START: begin
                        if (cur_ph == mtb_pkg::PH_CREATED || cur_ph == mtb_pkg::PH_STOPPED) begin
                            wr_cnt = (cur_dly != '0) ? cur_dly : cur_per;
                            wr_ph  = mtb_pkg::PH_STARTED;
                        end else begin
                            wr_status = 1'b1;
                        end
                    end
                    mtb_pkg::ACT_STOP: begin
                        if (cur_ph == mtb_pkg::PH_STARTED) begin
                            wr_ph = mtb_pkg::PH_STOPPED;
                        end else begin
                            wr_status = 1'b1;
                        end
                    end
                    mtb_pkg::ACT_DESTROY: begin
                        wr_ph = mtb_pkg::PH_DESTROYED;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        res.timer  = (uw.uop == mtb_pkg::UOP_SCAN) ? mtb_pkg::ID_W'(r_idx) : r_id;
        res.fired  = (uw.uop == mtb_pkg::UOP_SCAN);
        res.status = wr_status;
        res.life   = wr_ph;
        res.dly    = wr_dly;
        res.per    = wr_per;
        res.kind   = wr_kind;
        res.rem    = wr_cnt;
        res.last   = (uw.uop == mtb_pkg::UOP_APPLY);
        if (uw.uop == mtb_pkg::UOP_APPLY && bad_id) begin
            res        = '0;
            res.timer  = r_id;
            res.status = 1'b1;
            res.last   = 1'b1;
        end

        case (uw.uop)
            mtb_pkg::UOP_FETCH: begin
                if (in_acc) begin
                    n_act       = i_action;
                    n_id        = i_timer_id;
                    n_in_dly    = i_start_delay;
                    n_in_per    = i_period;
                    n_in_hard   = i_hard_kind;
                    n_idx       = '0;
                    n_nrep      = '0;
                    st.go_tick  = (i_action == mtb_pkg::ACT_TICK);
                    st.go_apply = (i_action != mtb_pkg::ACT_TICK) &&
                                  (i_action <= mtb_pkg::ACT_QUERY);
                end
            end
            mtb_pkg::UOP_SCAN: begin
                if (!blocked) begin
                    wr_en      = sel;
                    st.advance = (int'(r_idx) == NT - 1);
                    n_idx      = st.advance ? '0 : r_idx + IW'(1);
                    if (report) begin
                        n_pend_valid = 1'b1;
                        n_pend       = res;
                        n_nrep       = r_nrep + mtb_pkg::NREP_W'(1);
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                        end
                    end
                end
            end
            mtb_pkg::UOP_FLUSH: begin
                if (!r_pend_valid) begin
                    st.advance = 1'b1;
                end else if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out         = r_pend;
                    n_out.last    = 1'b1;
                    n_pend_valid  = 1'b0;
                    st.advance    = 1'b1;
                end
            end
            mtb_pkg::UOP_APPLY: begin
                if (out_free) begin
                    wr_en       = !bad_id;
                    n_out_valid = 1'b1;
                    n_out       = res;
                    st.advance  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NT; i++) begin
                r_dly[i]  <= '0;
                r_per[i]  <= '0;
                r_cnt[i]  <= '0;
                r_kind[i] <= 1'b0;
                r_ph[i]   <= mtb_pkg::PH_UNUSED;
            end
        end else if (wr_en) begin
            r_dly[rd_idx]  <= wr_dly;
            r_per[rd_idx]  <= wr_per;
            r_cnt[rd_idx]  <= wr_cnt;
            r_kind[rd_idx] <= wr_kind;
            r_ph[rd_idx]   <= wr_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_nrep       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_idx        <= n_idx;
            r_nrep       <= n_nrep;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_id      <= n_id;
        r_in_dly  <= n_in_dly;
        r_in_per  <= n_in_per;
        r_in_hard <= n_in_hard;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_timer = r_out.timer;
    assign o_fired        = r_out.fired;
    assign o_status       = r_out.status;
    assign o_life_state   = r_out.life;
    assign o_delay_out    = r_out.dly;
    assign o_period_out   = r_out.per;
    assign o_kind_out     = r_out.kind;
    assign o_remaining    = r_out.rem;
    assign o_last         = r_out.last;

`ifndef SYNTHESIS
    a_no_pend_at_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.uop == mtb_pkg::UOP_FETCH) |-> !r_pend_valid)
        else $error("staged tick result left behind after flush");

    a_nrep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_nrep) <= mtb_pkg::MAX_RES)
        else $error("tick result count beyond limit");

    a_not_last_is_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> r_out.fired)
        else $error("non-final result outside a tick");

    a_fire_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fired) |-> (!r_out.status && (int'(r_out.timer) < NT)))
        else $error("tick result with bad status or timer");
`endif

endmodule

[test/timer_bank_check_pkg.sv]
// Timer bank shadow state and result checker for the testbench.
`timescale 1ns / 1ps

package timer_bank_check_pkg;

    import mtb_pkg::*;

    class timer_bank_shadow;

        logic [COUNT_W-1:0] shadow_delay [NUM_TIMERS];
        logic [COUNT_W-1:0] shadow_period[NUM_TIMERS];
        logic [COUNT_W-1:0] shadow_count [NUM_TIMERS];
        logic               shadow_kind  [NUM_TIMERS];
        t_phase             shadow_phase [NUM_TIMERS];
        t_result            awaited_reports[$];
        int                 mismatches;

        function new();
            for (int t = 0; t < NUM_TIMERS; t++) begin
                shadow_delay[t]  = '0;
                shadow_period[t] = '0;
                shadow_count[t]  = '0;
                shadow_kind[t]   = 1'b0;
                shadow_phase[t]  = PH_UNUSED;
            end
            mismatches = 0;
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction

        function logic [COUNT_W-1:0] reload_value(int t);
            return (shadow_delay[t] != '0) ? shadow_delay[t] : shadow_period[t];
        endfunction

        function t_result report_of(int t, logic fired, logic status, logic last);
            return '{timer: ID_W'(t), fired: fired, status: status, life: shadow_phase[t],
                     dly: shadow_delay[t], per: shadow_period[t], kind: shadow_kind[t],
                     rem: shadow_count[t], last: last};
        endfunction

        // Works out the reports caused by one accepted request.
        function void note_request(logic [2:0] act, logic [ID_W-1:0] id,
                                   logic [COUNT_W-1:0] dly, logic [COUNT_W-1:0] per,
                                   logic kind);
            t_result held;
            bit      have_held;
            bit      status;
            have_held = 0;
            status    = 0;
            if (act == ACT_TICK) begin
                for (int pass = 0; pass < 2; pass++) begin
                    for (int t = 0; t < NUM_TIMERS; t++) begin
                        if (shadow_phase[t] != PH_STARTED || shadow_kind[t] != (pass == 0))
                            continue;
                        if (shadow_count[t] != '0) begin
                            shadow_count[t] = shadow_count[t] - 1'b1;
                            if (shadow_count[t] != '0)
                                continue;
                        end
                        if (shadow_period[t] != '0)
                            shadow_count[t] = shadow_period[t];
                        else
                            shadow_phase[t] = PH_STOPPED;
                        if (have_held)
                            awaited_reports.push_back(held);
                        held      = report_of(t, 1'b1, 1'b0, 1'b0);
                        have_held = 1;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    awaited_reports.push_back(held);
                end
                return;
            end
            if (act > ACT_QUERY)
                return;
            case (t_action'(act))
                ACT_INIT: begin
                    shadow_delay[id]  = dly;
                    shadow_period[id] = per;
                    shadow_kind[id]   = kind;
                    shadow_count[id]  = reload_value(id);
                    shadow_phase[id]  = PH_CREATED;
                end
                ACT_START: begin
                    if (shadow_phase[id] == PH_CREATED || shadow_phase[id] == PH_STOPPED) begin
                        shadow_count[id] = reload_value(id);
                        shadow_phase[id] = PH_STARTED;
                    end else begin
                        status = 1;
                    end
                end
                ACT_STOP: begin
                    if (shadow_phase[id] == PH_STARTED)
                        shadow_phase[id] = PH_STOPPED;
                    else
                        status = 1;
                end
                ACT_DESTROY: shadow_phase[id] = PH_DESTROYED;
                default: ;
            endcase
            awaited_reports.push_back(report_of(id, 1'b0, status, 1'b1));
        endfunction

        function void compare_field(string name, logic [COUNT_W-1:0] want,
                                    logic [COUNT_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited_reports.size() == 0) begin
                mismatches++;
                $display("%0t: result for timer %0d with none expected, expected none actual %p",
                         $time, got.timer, got);
                return;
            end
            want = awaited_reports.pop_front();
            compare_field("result_timer", COUNT_W'(want.timer), COUNT_W'(got.timer));
            compare_field("fired", COUNT_W'(want.fired), COUNT_W'(got.fired));
            compare_field("status", COUNT_W'(want.status), COUNT_W'(got.status));
            compare_field("life_state", COUNT_W'(want.life), COUNT_W'(got.life));
            compare_field("delay_out", want.dly, got.dly);
            compare_field("period_out", want.per, got.per);
            compare_field("kind_out", COUNT_W'(want.kind), COUNT_W'(got.kind));
            compare_field("remaining", want.rem, got.rem);
            compare_field("last", COUNT_W'(want.last), COUNT_W'(got.last));
        endfunction

    endclass

endpackage

[test/tb_multi_timer_bank_unit.sv]
// Testbench for the timer bank: directed and random requests against a shadow model.
`timescale 1ns / 1ps

module tb_multi_timer_bank_unit;

    import mtb_pkg::*;
    import timer_bank_check_pkg::*;

    localparam int         RANDOM_ITEMS = 160;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         SETTLE_WAIT  = 2 * NUM_TIMERS + 8;
    localparam logic [2:0] ACT_RSVD_A   = 3'd6;
    localparam logic [2:0] ACT_RSVD_B   = 3'd7;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [2:0]           i_action      = '0;
    logic [ID_W-1:0]      i_timer_id    = '0;
    logic [COUNT_W-1:0]   i_start_delay = '0;
    logic [COUNT_W-1:0]   i_period      = '0;
    logic                 i_hard_kind   = 1'b0;
    logic                 i_out_stall   = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [ID_W-1:0]      o_result_timer;
    logic                 o_fired;
    logic                 o_status;
    logic [2:0]           o_life_state;
    logic [COUNT_W-1:0]   o_delay_out;
    logic [COUNT_W-1:0]   o_period_out;
    logic                 o_kind_out;
    logic [COUNT_W-1:0]   o_remaining;
    logic                 o_last;

    int                   in_idle_pct   = 24;
    int                   out_stall_pct = 84;
    int                   cycles        = 0;
    timer_bank_shadow     bank_shadow;

    multi_timer_bank_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb_multi_timer_bank_unit: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            bank_shadow.check_result(t_result'{timer: o_result_timer, fired: o_fired,
                                               status: o_status,
                                               life: t_phase'(o_life_state),
                                               dly: o_delay_out, per: o_period_out,
                                               kind: o_kind_out, rem: o_remaining,
                                               last: o_last});
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    task automatic send_request(input logic [2:0] act, input logic [ID_W-1:0] id,
                                input logic [COUNT_W-1:0] dly, input logic [COUNT_W-1:0] per,
                                input logic kind);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_timer_id    <= id;
        i_start_delay <= dly;
        i_period      <= per;
        i_hard_kind   <= kind;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bank_shadow.note_request(act, id, dly, per, kind);
    endtask

    task automatic wait_for_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (bank_shadow.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly short counts so that ticks fire often; full-width values now and then.
    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return COUNT_W'($urandom_range(0, 4));
        else if (r < 82)
            return COUNT_W'($urandom);
        else if (r < 90)
            return '1;
        return COUNT_W'($urandom_range(1, 3));
    endfunction

    task automatic random_request(output bit counted);
        logic [2:0] act;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            act = ACT_INIT;
        else if (pick < 42)
            act = ACT_START;
        else if (pick < 50)
            act = ACT_STOP;
        else if (pick < 54)
            act = ACT_DESTROY;
        else if (pick < 62)
            act = ACT_QUERY;
        else if (pick < 97)
            act = ACT_TICK;
        else
            act = pick[0] ? ACT_RSVD_A : ACT_RSVD_B;
        counted = (act <= ACT_QUERY);
        send_request(act, ID_W'($urandom_range(0, NUM_TIMERS - 1)), pick_count(), pick_count(),
                     1'($urandom_range(0, 1)));
    endtask

    initial begin
        int sent;
        int phase_no;
        bit counted;
        bank_shadow = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(ACT_INIT,    4'd0,  '0, '0, 1'b0);
        send_request(ACT_INIT,    4'd15, '1, '1, 1'b1);
        send_request(ACT_QUERY,   4'd15, '0, '0, 1'b0);
        send_request(ACT_QUERY,   4'd3,  '0, '0, 1'b0);
        send_request(ACT_START,   4'd3,  '0, '0, 1'b0);
        send_request(ACT_STOP,    4'd0,  '0, '0, 1'b0);
        send_request(ACT_START,   4'd0,  '0, '0, 1'b0);
        send_request(ACT_START,   4'd0,  '0, '0, 1'b0);
        send_request(ACT_INIT,    4'd1,  32'd0, 32'd2, 1'b0);
        send_request(ACT_START,   4'd1,  '0, '0, 1'b0);
        send_request(ACT_INIT,    4'd2,  32'd1, 32'd0, 1'b1);
        send_request(ACT_START,   4'd2,  '0, '0, 1'b0);
        send_request(ACT_INIT,    4'd4,  32'd2, 32'd1, 1'b1);
        send_request(ACT_START,   4'd4,  '0, '0, 1'b0);
        send_request(ACT_TICK,    4'd9,  '1, '1, 1'b1);
        send_request(ACT_TICK,    4'd0,  '0, '0, 1'b0);
        send_request(ACT_START,   4'd15, '0, '0, 1'b0);
        send_request(ACT_STOP,    4'd15, '0, '0, 1'b0);
        send_request(ACT_START,   4'd15, '0, '0, 1'b0);
        send_request(ACT_DESTROY, 4'd15, '0, '0, 1'b0);
        send_request(ACT_START,   4'd15, '0, '0, 1'b0);
        send_request(ACT_STOP,    4'd15, '0, '0, 1'b0);
        send_request(ACT_RSVD_A,  4'd5,  '0, '0, 1'b0);
        send_request(ACT_RSVD_B,  4'd6,  '0, '0, 1'b0);
        send_request(ACT_TICK,    4'd0,  '0, '0, 1'b0);

        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent * 3 / RANDOM_ITEMS > phase_no) begin
                phase_no++;
                wait_for_quiet();
                in_idle_pct   = (phase_no == 1) ? 84 : 0;
                out_stall_pct = (phase_no == 1) ? 24 : 0;
            end
            random_request(counted);
            if (counted)
                sent++;
        end

        wait_for_quiet();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (bank_shadow.mismatches == 0 && bank_shadow.pending() == 0)
            $display("tb_multi_timer_bank_unit: PASS");
        else
            $display("tb_multi_timer_bank_unit: FAIL");
        $finish;
    end

endmodule
